>>> rtl/atad_pkg.sv
// ----------------------------------------------------------------------------
// atad_pkg: shared types, constants and control store for the awake-time adapter
// Holds the event codes, register indexes, micro-op and jump-condition codes,
// and the control store that the sequencer steps through.
// ----------------------------------------------------------------------------
package atad_pkg;

  // gap window geometry
  localparam int WINDOW_LEN = 8;
  localparam int IDX_W      = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;

  // field widths
  localparam int OP_W    = 2;
  localparam int TIME_W  = 64;
  localparam int AWAKE_W = 16;
  localparam int CFG_W   = 16;
  localparam int CFG_A_W = 2;

  // beat payload widths (padded to whole bytes)
  localparam int IN_DATA_W  = 72;
  localparam int OUT_DATA_W = 24;

  localparam logic [AWAKE_W-1:0] GAP_SAT       = 16'hffff;
  localparam logic [AWAKE_W-1:0] AWAKE_DEFAULT = 16'd5000;

  // event codes carried on in_tuser
  typedef enum logic [OP_W-1:0] {
    EV_REQUEST = 2'd0,
    EV_ARM     = 2'd1,
    EV_NOTIFY  = 2'd2,
    EV_UNUSED  = 2'd3
  } event_t;

  // configuration register indexes
  typedef enum logic [CFG_A_W-1:0] {
    REG_ADAPT_EN = 2'd0,
    REG_USE_MEAN = 2'd1,
    REG_INIT_AWK = 2'd2,
    REG_NONE     = 2'd3
  } reg_idx_t;

  // datapath actions, one per control word
  typedef enum logic [2:0] {
    UOP_NOP,
    UOP_DECODE,
    UOP_PUSH,
    UOP_SCAN,
    UOP_AWAKE,
    UOP_FIRST,
    UOP_EMIT
  } uop_t;

  // jump conditions
  typedef enum logic [2:0] {
    JC_NEVER,
    JC_ALWAYS,
    JC_NO_BEAT,
    JC_NOT_ADAPT,
    JC_FIRST,
    JC_SCAN_MORE,
    JC_OUT_BUSY
  } cond_t;

  localparam int STEP_W = 3;
  typedef logic [STEP_W-1:0] step_t;

  // program addresses
  localparam step_t ST_WAIT   = 3'd0;
  localparam step_t ST_DECODE = 3'd1;
  localparam step_t ST_BRANCH = 3'd2;
  localparam step_t ST_PUSH   = 3'd3;
  localparam step_t ST_SCAN   = 3'd4;
  localparam step_t ST_AWAKE  = 3'd5;
  localparam step_t ST_FIRST  = 3'd6;
  localparam step_t ST_EMIT   = 3'd7;

  typedef struct packed {
    uop_t  uop;
    cond_t cond;
    step_t target;
    logic  fin;     // return to ST_WAIT when the jump is not taken
  } ctrl_word_t;

  // status flags reported by the datapath for jump decisions
  typedef struct packed {
    logic not_adapt;
    logic first;
    logic scan_more;
    logic out_busy;
  } dp_status_t;

  // control store
  function automatic ctrl_word_t ucode(input step_t pc);
    ctrl_word_t w;
    w = '{uop: UOP_NOP, cond: JC_NEVER, target: ST_WAIT, fin: 1'b1};
    unique case (pc)
      ST_WAIT:   w = '{uop: UOP_NOP,    cond: JC_NO_BEAT,   target: ST_WAIT,  fin: 1'b0};
      ST_DECODE: w = '{uop: UOP_DECODE, cond: JC_NOT_ADAPT, target: ST_EMIT,  fin: 1'b0};
      ST_BRANCH: w = '{uop: UOP_NOP,    cond: JC_FIRST,     target: ST_FIRST, fin: 1'b0};
      ST_PUSH:   w = '{uop: UOP_PUSH,   cond: JC_NEVER,     target: ST_WAIT,  fin: 1'b0};
      ST_SCAN:   w = '{uop: UOP_SCAN,   cond: JC_SCAN_MORE, target: ST_SCAN,  fin: 1'b0};
      ST_AWAKE:  w = '{uop: UOP_AWAKE,  cond: JC_ALWAYS,    target: ST_EMIT,  fin: 1'b0};
      ST_FIRST:  w = '{uop: UOP_FIRST,  cond: JC_ALWAYS,    target: ST_EMIT,  fin: 1'b0};
      ST_EMIT:   w = '{uop: UOP_EMIT,   cond: JC_OUT_BUSY,  target: ST_EMIT,  fin: 1'b1};
      default:   w = '{uop: UOP_NOP,    cond: JC_NEVER,     target: ST_WAIT,  fin: 1'b1};
    endcase
    return w;
  endfunction

endpackage

>>> rtl/awake_time_adapter_top.sv
// ----------------------------------------------------------------------------
// awake_time_adapter_top: awake-time adapter
// Tracks request gaps in a ring window and derives the awake time from the
// window maximum or a pairwise running mean.
// ----------------------------------------------------------------------------
//
//  channel | dir | handshake            | payload
//  --------+-----+----------------------+------------------------------------
//  in_     | in  | in_tvalid/in_tready  | tdata: now_ms, client_awake; tuser: op
//  out_    | out | out_tvalid/out_tready| tdata: awake_ms, window_updated,
//          |     |                      |        restart_awake_timer
//  cfg_    | in  | cfg_wr_en            | cfg_addr, cfg_wdata
//
//  A request that records a gap holds the sequencer through its accept, decode,
//  branch, push, scan, awake and emit steps; the scan step repeats once per
//  window entry, reading one entry per cycle. Other events go from decode
//  straight to emit, or for the first request after arming through branch and first to emit. One event is in work at a
//  time; in_tready is high only while the sequencer waits at its first step
//  out of reset, and a result waits in the output register without blocking
//  the next beat. A stalled result holds the sequencer at its emit step.
//  Synchronous active-low reset; all window entries clear at reset, no
//  clearing pass.
//
module awake_time_adapter_top (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  input  logic [atad_pkg::IN_DATA_W-1:0]        in_tdata,   // [63:0] now_ms, [64] client_awake
  input  logic [atad_pkg::OP_W-1:0]             in_tuser,   // [1:0] op
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  output logic [atad_pkg::OUT_DATA_W-1:0]       out_tdata,  // [15:0] awake_ms,
                                                            // [16] window_updated,
                                                            // [17] restart_awake_timer
  input  logic                                  cfg_wr_en,
  input  logic [atad_pkg::CFG_A_W-1:0]          cfg_addr,
  input  logic [atad_pkg::CFG_W-1:0]            cfg_wdata
);

  atad_pkg::uop_t               uop;
  atad_pkg::dp_status_t         status;
  logic                         idle;
  logic                         in_beat;
  logic [atad_pkg::AWAKE_W-1:0] awake_ms;
  logic                         updated;
  logic                         restart;

  // no beat taken while in reset
  assign in_tready = idle && rst_n;
  assign in_beat   = in_tvalid && in_tready;

  atad_seq u_seq (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_beat (in_beat),
    .status  (status),
    .uop     (uop),
    .idle    (idle)
  );

  atad_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .uop         (uop),
    .status      (status),
    .in_beat     (in_beat),
    .in_op       (in_tuser),
    .in_now      (in_tdata[atad_pkg::TIME_W-1:0]),
    .in_awake    (in_tdata[atad_pkg::TIME_W]),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_addr    (cfg_addr),
    .cfg_wdata   (cfg_wdata),
    .out_tready  (out_tready),
    .out_valid   (out_tvalid),
    .out_awake   (awake_ms),
    .out_updated (updated),
    .out_restart (restart)
  );

  // pack result beat, pad to bytes
  assign out_tdata = {6'b000000, restart, updated, awake_ms};

endmodule

>>> rtl/atad_seq.sv
// ----------------------------------------------------------------------------
// atad_seq: micro-sequencer
// Step counter over the control store with conditional jumps on datapath
// status; issues one micro-op per cycle.
// ----------------------------------------------------------------------------
module atad_seq (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_beat,
  input  atad_pkg::dp_status_t  status,
  output atad_pkg::uop_t        uop,
  output logic                  idle
);

  atad_pkg::step_t      pc_r, pc_nxt;
  atad_pkg::ctrl_word_t word;
  logic                 take;

  // fetch
  assign word = atad_pkg::ucode(pc_r);
  assign uop  = word.uop;
  assign idle = (pc_r == atad_pkg::ST_WAIT);

  // jump decision
  always_comb begin
    unique case (word.cond)
      atad_pkg::JC_NEVER:     take = 1'b0;
      atad_pkg::JC_ALWAYS:    take = 1'b1;
      atad_pkg::JC_NO_BEAT:   take = !in_beat;
      atad_pkg::JC_NOT_ADAPT: take = status.not_adapt;
      atad_pkg::JC_FIRST:     take = status.first;
      atad_pkg::JC_SCAN_MORE: take = status.scan_more;
      atad_pkg::JC_OUT_BUSY:  take = status.out_busy;
      default:                take = 1'b0;
    endcase
  end

  always_comb begin
    priority if (take) begin
      pc_nxt = word.target;
    end else if (word.fin) begin
      pc_nxt = atad_pkg::ST_WAIT;
    end else begin
      pc_nxt = pc_r + atad_pkg::step_t'(1);
    end
  end

  // step counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= atad_pkg::ST_WAIT;
    end else begin
      pc_r <= pc_nxt;
    end
  end

endmodule

>>> rtl/atad_dp.sv
// ----------------------------------------------------------------------------
// atad_dp: adapter datapath
// Config registers, event flags, gap window, scan accumulator and the
// result register, all driven by the sequencer's micro-op.
// ----------------------------------------------------------------------------
module atad_dp (
  input  logic                            clk,
  input  logic                            rst_n,
  input  atad_pkg::uop_t                  uop,
  output atad_pkg::dp_status_t            status,
  // input beat
  input  logic                            in_beat,
  input  logic [atad_pkg::OP_W-1:0]       in_op,
  input  logic [atad_pkg::TIME_W-1:0]     in_now,
  input  logic                            in_awake,
  // config writes
  input  logic                            cfg_wr_en,
  input  logic [atad_pkg::CFG_A_W-1:0]    cfg_addr,
  input  logic [atad_pkg::CFG_W-1:0]      cfg_wdata,
  // result register
  input  logic                            out_tready,
  output logic                            out_valid,
  output logic [atad_pkg::AWAKE_W-1:0]    out_awake,
  output logic                            out_updated,
  output logic                            out_restart
);

  localparam logic [atad_pkg::IDX_W-1:0] IDX_LAST =
    atad_pkg::IDX_W'(atad_pkg::WINDOW_LEN - 1);
  localparam logic [atad_pkg::IDX_W-1:0] IDX_ONE = atad_pkg::IDX_W'(1);

  // config and state
  logic                          adapt_en_r;
  logic                          use_mean_r;
  logic [atad_pkg::AWAKE_W-1:0]  awake_r;
  logic                          first_r;
  logic                          notify_r;
  logic [atad_pkg::TIME_W-1:0]   last_r;
  logic [atad_pkg::IDX_W-1:0]    slot_r;
  logic [atad_pkg::AWAKE_W-1:0]  win_r [atad_pkg::WINDOW_LEN];

  // latched beat
  atad_pkg::event_t              op_r;
  logic [atad_pkg::TIME_W-1:0]   now_r;
  logic                          awk_r;

  // per-event work
  logic                          updated_r;
  logic                          restart_r;
  logic [atad_pkg::IDX_W-1:0]    idx_r;
  logic [atad_pkg::AWAKE_W-1:0]  acc_r;

  logic                          out_valid_r;
  logic [atad_pkg::AWAKE_W-1:0]  out_awake_r;
  logic                          out_updated_r;
  logic                          out_restart_r;

  logic [atad_pkg::TIME_W-1:0]   diff;
  logic [atad_pkg::AWAKE_W-1:0]  gap_sat;
  logic [atad_pkg::AWAKE_W-1:0]  cur;
  logic [atad_pkg::AWAKE_W:0]    pair_sum;
  logic [atad_pkg::AWAKE_W-1:0]  acc_nxt;
  logic [atad_pkg::AWAKE_W:0]    awake_sum;
  logic                          out_busy;

  // gap since last request, saturated
  assign diff    = now_r - last_r;
  assign gap_sat = (|diff[atad_pkg::TIME_W-1:atad_pkg::AWAKE_W]) ?
                   atad_pkg::GAP_SAT : diff[atad_pkg::AWAKE_W-1:0];

  // one window entry per scan step
  assign cur      = win_r[idx_r];
  assign pair_sum = {1'b0, acc_r} + {1'b0, cur};

  always_comb begin
    if (use_mean_r) begin
      priority if (acc_r == '0) begin
        acc_nxt = cur;
      end else if (cur != '0) begin
        acc_nxt = pair_sum[atad_pkg::AWAKE_W:1];
      end else begin
        acc_nxt = acc_r;
      end
    end else begin
      acc_nxt = (cur > acc_r) ? cur : acc_r;
    end
  end

  // V + V/2, wraps at 16 bits
  assign awake_sum = {1'b0, acc_r} + {2'b00, acc_r[atad_pkg::AWAKE_W-1:1]};

  assign out_busy = out_valid_r && !out_tready;

  assign status.not_adapt = !((op_r == atad_pkg::EV_REQUEST) && adapt_en_r && !notify_r);
  assign status.first     = first_r;
  assign status.scan_more = (idx_r != IDX_LAST);
  assign status.out_busy  = out_busy;

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      adapt_en_r  <= 1'b1;
      use_mean_r  <= 1'b0;
      awake_r     <= atad_pkg::AWAKE_DEFAULT;
      first_r     <= 1'b0;
      notify_r    <= 1'b0;
      last_r      <= '0;
      slot_r      <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < atad_pkg::WINDOW_LEN; i++) begin
        win_r[i] <= '0;
      end
    end else begin
      // config port; the user must write it only while idle, the block does not enforce this
      if (cfg_wr_en) begin
        unique case (atad_pkg::reg_idx_t'(cfg_addr))
          atad_pkg::REG_ADAPT_EN: adapt_en_r <= cfg_wdata[0];
          atad_pkg::REG_USE_MEAN: use_mean_r <= cfg_wdata[0];
          atad_pkg::REG_INIT_AWK: awake_r    <= cfg_wdata;
          default: ;
        endcase
      end

      if (out_valid_r && out_tready) begin
        out_valid_r <= 1'b0;
      end

      unique case (uop)
        atad_pkg::UOP_DECODE: begin
          unique case (op_r)
            atad_pkg::EV_REQUEST: notify_r <= 1'b0;
            atad_pkg::EV_ARM:     first_r  <= 1'b1;
            atad_pkg::EV_NOTIFY:  notify_r <= 1'b1;
            default: ;
          endcase
        end
        atad_pkg::UOP_PUSH: begin
          win_r[slot_r] <= gap_sat;
          slot_r        <= (slot_r == IDX_LAST) ? '0 : slot_r + IDX_ONE;
          last_r        <= now_r;
        end
        atad_pkg::UOP_FIRST: begin
          first_r <= 1'b0;
          last_r  <= now_r;
        end
        atad_pkg::UOP_AWAKE: begin
          awake_r <= awake_sum[atad_pkg::AWAKE_W-1:0];
        end
        atad_pkg::UOP_EMIT: begin
          if (!out_busy) begin
            out_valid_r <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_beat) begin
      op_r  <= atad_pkg::event_t'(in_op);
      now_r <= in_now;
      awk_r <= in_awake;
    end
    unique case (uop)
      atad_pkg::UOP_DECODE: begin
        updated_r <= 1'b0;
        restart_r <= (op_r == atad_pkg::EV_REQUEST) && awk_r;
      end
      atad_pkg::UOP_PUSH: begin
        updated_r <= 1'b1;
        idx_r     <= '0;
        acc_r     <= '0;
      end
      atad_pkg::UOP_SCAN: begin
        acc_r <= acc_nxt;
        idx_r <= idx_r + IDX_ONE;
      end
      atad_pkg::UOP_EMIT: begin
        if (!out_busy) begin
          out_awake_r   <= awake_r;
          out_updated_r <= updated_r;
          out_restart_r <= restart_r;
        end
      end
      default: ;
    endcase
  end

  assign out_valid   = out_valid_r;
  assign out_awake   = out_awake_r;
  assign out_updated = out_updated_r;
  assign out_restart = out_restart_r;

endmodule

>>> rtl/atad_checker.sv
// ----------------------------------------------------------------------------
// atad_checker: port-level checks for the awake-time adapter
// Watches the top level's ports only; bound to the top level below.
// ----------------------------------------------------------------------------
module atad_checker (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  input  logic                             in_tready,
  input  logic                             out_tvalid,
  input  logic                             out_tready,
  input  logic [atad_pkg::OUT_DATA_W-1:0]  out_tdata
);

  // stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result beat changed while stalled");

  // reset leaves no result pending
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // one event in work at a time: input closes after a beat
  a_one_in_work: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input open right after a beat");

  // an accepted event passes decode before its result shows
  a_min_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && !out_tvalid |=> !out_tvalid)
    else $error("result appeared too early");

  // padding bits stay zero
  a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[atad_pkg::OUT_DATA_W-1:18] == '0)
    else $error("nonzero padding in result beat");

endmodule

bind awake_time_adapter_top atad_checker u_atad_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

>>> tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for awake_time_adapter_top
// Sends request, arm, notify and unused events over the input stream and
// predicts each result beat with a local model of the gap window and awake
// time. Results are compared field by field in order of arrival, with random
// gaps and stalls on both streams and register changes between phases.
// ----------------------------------------------------------------------------
module tb;
  import atad_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASES      = 12;
  localparam int PHASE_BEATS = 100;

  typedef struct {
    logic [AWAKE_W-1:0] awake_ms;
    logic               win_upd;
    logic               restart;
  } awake_result_t;

  // --------------------------------------------------------------------------
  // awake-time scoreboard: local model of the adapter plus expected results
  // --------------------------------------------------------------------------
  class awake_scoreboard;
    bit                 adapt_en;
    bit                 mean_mode;
    logic [AWAKE_W-1:0] init_awake;
    logic [AWAKE_W-1:0] gaps [WINDOW_LEN];
    int                 slot;
    logic [TIME_W-1:0]  last_req;
    bit                 arm_flag;
    bit                 notify_mark;
    logic [AWAKE_W-1:0] awake;
    awake_result_t      awake_q[$];
    int                 errors;
    int                 n_events;
    int                 n_checked;
    int                 n_gaps;
    int                 n_restarts;

    function new();
      adapt_en    = 1'b1;
      mean_mode   = 1'b0;
      init_awake  = AWAKE_DEFAULT;
      foreach (gaps[i]) gaps[i] = '0;
      slot        = 0;
      last_req    = '0;
      arm_flag    = 1'b0;
      notify_mark = 1'b0;
      awake       = AWAKE_DEFAULT;
    endfunction

    function void write_reg(reg_idx_t idx, logic [CFG_W-1:0] val);
      case (idx)
        REG_ADAPT_EN: adapt_en = val[0];
        REG_USE_MEAN: mean_mode = val[0];
        REG_INIT_AWK: begin
          init_awake = val;
          awake      = val;
        end
        default: ;
      endcase
    endfunction

    // accepted input beat: advance the model and queue the result it causes
    function void note_event(event_t ev, logic [TIME_W-1:0] now, logic awake_in);
      awake_result_t      r;
      logic [TIME_W-1:0]  gap;
      int unsigned        v;
      int unsigned        scaled;
      r.win_upd = 1'b0;
      r.restart = 1'b0;
      case (ev)
        EV_REQUEST: begin
          r.restart = awake_in;
          if (adapt_en && !notify_mark) begin
            if (arm_flag) begin
              arm_flag = 1'b0;
            end else begin
              gap = now - last_req;
              if (slot >= WINDOW_LEN) slot = 0;
              gaps[slot] = (gap > 64'hffff) ? GAP_SAT : gap[AWAKE_W-1:0];
              slot++;
              // window maximum, or pairwise mean that skips zero entries
              v = 0;
              for (int i = 0; i < WINDOW_LEN; i++) begin
                if (mean_mode) begin
                  if (v == 0) v = gaps[i];
                  else if (gaps[i] != 0) v = (v + gaps[i]) / 2;
                end else if (gaps[i] > v) begin
                  v = gaps[i];
                end
              end
              scaled    = v + (v >> 1);
              awake     = scaled[AWAKE_W-1:0];
              r.win_upd = 1'b1;
              n_gaps++;
            end
            last_req = now;
          end
          notify_mark = 1'b0;
        end
        EV_ARM:    arm_flag = 1'b1;
        EV_NOTIFY: notify_mark = 1'b1;
        default: ;
      endcase
      r.awake_ms = awake;
      if (r.restart) n_restarts++;
      n_events++;
      awake_q.push_back(r);
    endfunction

    // accepted result beat: compare against the oldest expectation
    function void check_result(logic [OUT_DATA_W-1:0] d);
      awake_result_t e;
      if (awake_q.size() == 0) begin
        $error("result beat with nothing expected: tdata=%h", d);
        errors++;
        return;
      end
      e = awake_q.pop_front();
      n_checked++;
      if (d[15:0] !== e.awake_ms) begin
        $error("awake_ms: expected %0d, got %0d", e.awake_ms, d[15:0]);
        errors++;
      end
      if (d[16] !== e.win_upd) begin
        $error("window_updated: expected %0b, got %0b", e.win_upd, d[16]);
        errors++;
      end
      if (d[17] !== e.restart) begin
        $error("restart_awake_timer: expected %0b, got %0b", e.restart, d[17]);
        errors++;
      end
    endfunction

    function int pending();
      return awake_q.size();
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // clock, DUT signals and instance
  // --------------------------------------------------------------------------
  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    in_tvalid = 1'b0;
  logic                    in_tready;
  logic [IN_DATA_W-1:0]    in_tdata = '0;
  logic [OP_W-1:0]         in_tuser = '0;
  logic                    out_tvalid;
  logic                    out_tready = 1'b0;
  logic [OUT_DATA_W-1:0]   out_tdata;
  logic                    cfg_wr_en = 1'b0;
  logic [CFG_A_W-1:0]      cfg_addr = '0;
  logic [CFG_W-1:0]        cfg_wdata = '0;

  awake_scoreboard sb = new();
  bit              in_quiet;
  bit              out_quiet;
  bit              sink_on;
  int              cycle_cnt;
  int              n_settings;
  logic [TIME_W-1:0] cur_time;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  awake_time_adapter_top i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  // run limit
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  function automatic int draw_wait(bit quiet);
    return quiet ? 0 : $urandom_range(0, 14);
  endfunction

  // --------------------------------------------------------------------------
  // result sink: random stalls, check at each accepted beat
  // --------------------------------------------------------------------------
  initial begin
    int n;
    wait (sink_on);
    forever begin
      n = draw_wait(out_quiet);
      if (n > 0) begin
        out_tready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      sb.check_result(out_tdata);
    end
  end

  // --------------------------------------------------------------------------
  // driver tasks
  // --------------------------------------------------------------------------
  task automatic send_event(event_t ev, logic [TIME_W-1:0] now, logic awake_in);
    int n;
    n = draw_wait(in_quiet);
    if (n > 0) begin
      in_tvalid <= 1'b0;
      repeat (n) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {7'd0, awake_in, now};
    in_tuser  <= ev;
    do @(posedge clk); while (!in_tready);
    sb.note_event(ev, now, awake_in);
  endtask

  // stop sending and wait for every expected result
  task automatic drain();
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // block is idle here; one register per edge, enable dropped after the batch
  task automatic write_settings(bit adapt, bit mean, bit load_init, logic [CFG_W-1:0] init);
    cfg_wr_en <= 1'b1;
    cfg_addr  <= REG_ADAPT_EN;
    cfg_wdata <= {15'd0, adapt};
    @(posedge clk);
    sb.write_reg(REG_ADAPT_EN, {15'd0, adapt});
    cfg_addr  <= REG_USE_MEAN;
    cfg_wdata <= {15'd0, mean};
    @(posedge clk);
    sb.write_reg(REG_USE_MEAN, {15'd0, mean});
    if (load_init) begin
      cfg_addr  <= REG_INIT_AWK;
      cfg_wdata <= init;
      @(posedge clk);
      sb.write_reg(REG_INIT_AWK, init);
    end
    cfg_wr_en <= 1'b0;
    n_settings++;
  endtask

  task automatic random_event();
    int                r;
    logic [TIME_W-1:0] now;
    logic              awake_in;
    r        = $urandom_range(0, 99);
    awake_in = 1'($urandom_range(0, 1));
    if (r < 70) begin
      // normal request stream: mostly modest gaps, some past saturation
      if ($urandom_range(0, 9) == 0) cur_time += 64'($urandom_range(0, 200000));
      else cur_time += 64'($urandom_range(0, 3000));
      send_event(EV_REQUEST, cur_time, awake_in);
    end else if (r < 78) begin
      send_event(EV_ARM, {$urandom, $urandom}, awake_in);
    end else if (r < 86) begin
      send_event(EV_NOTIFY, {$urandom, $urandom}, awake_in);
    end else if (r < 90) begin
      send_event(EV_UNUSED, {$urandom, $urandom}, awake_in);
    end else if (r < 95) begin
      now      = {$urandom, $urandom};
      cur_time = now;
      send_event(EV_REQUEST, now, awake_in);
    end else begin
      // uptime going backwards
      now = cur_time - 64'($urandom_range(1, 100000));
      send_event(EV_REQUEST, now, awake_in);
    end
  endtask

  // --------------------------------------------------------------------------
  // main sequence
  // --------------------------------------------------------------------------
  initial begin
    bit                 load_init;
    logic [CFG_W-1:0]   init;
    repeat (7) @(posedge clk);
    rst_n   <= 1'b1;
    sink_on = 1'b1;

    // directed: reset settings (adaptation on, window maximum)
    send_event(EV_REQUEST, 64'd1000, 1'b1);
    send_event(EV_REQUEST, 64'hffff_ffff_ffff_ffff, 1'b0);
    send_event(EV_REQUEST, 64'd5, 1'b1);                 // time runs backwards
    send_event(EV_ARM, 64'd0, 1'b0);
    send_event(EV_REQUEST, 64'd100, 1'b0);               // first after arm: record only
    send_event(EV_REQUEST, 64'd100, 1'b1);               // zero gap
    send_event(EV_REQUEST, 64'd130, 1'b0);
    send_event(EV_NOTIFY, 64'hffff_ffff_ffff_ffff, 1'b1);
    send_event(EV_REQUEST, 64'd9999, 1'b1);              // marked: skipped
    send_event(EV_REQUEST, 64'd10050, 1'b0);
    send_event(EV_UNUSED, 64'hffff_ffff_ffff_ffff, 1'b1);
    // fill the window past its end so the write slot wraps
    cur_time = 64'd10050;
    for (int i = 0; i < 10; i++) begin
      cur_time += (i == 4) ? 64'd65536 : 64'(i * 7000 + 1);
      send_event(EV_REQUEST, cur_time, i[0]);
    end
    drain();

    // random phases, register settings changed between them
    for (int p = 0; p < PHASES; p++) begin
      in_quiet  = ($urandom_range(0, 3) == 0);
      out_quiet = ($urandom_range(0, 3) == 0);
      load_init = (p < 3) || $urandom_range(0, 1);
      init      = (p == 1) ? 16'd0 : (p == 2) ? 16'hffff : 16'($urandom);
      write_settings(p % 5 != 3, p[0], load_init, init);
      if ($urandom_range(0, 2) == 0) cur_time = {$urandom, $urandom};
      for (int k = 0; k < PHASE_BEATS; k++) begin
        random_event();
        // occasional hold-off until the block is empty
        if ($urandom_range(0, 63) == 0) drain();
      end
      drain();
    end

    repeat (30) @(posedge clk);
    $display("Covered %0d events in %0d register settings: %0d results checked,",
             sb.n_events, n_settings, sb.n_checked);
    $display("%0d gaps written to the window, %0d timer restarts.",
             sb.n_gaps, sb.n_restarts);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
